FILE: rtl/core/fpd_pkg.sv
package fpd_pkg;

	// Major opcodes of the floating-point groups
	localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
	localparam logic [6:0] OPC_STORE_FP = 7'h27;
	localparam logic [6:0] OPC_FMADD    = 7'h43;
	localparam logic [6:0] OPC_FMSUB    = 7'h47;
	localparam logic [6:0] OPC_FNMSUB   = 7'h4B;
	localparam logic [6:0] OPC_FNMADD   = 7'h4F;
	localparam logic [6:0] OPC_OP_FP    = 7'h53;

	// Load/store width codes
	localparam logic [2:0] WIDTH_W = 3'b010;
	localparam logic [2:0] WIDTH_D = 3'b011;

	// OP-FP funct7[6:2] groups
	localparam logic [4:0] F5_ADD   = 5'h00;
	localparam logic [4:0] F5_SUB   = 5'h01;
	localparam logic [4:0] F5_MUL   = 5'h02;
	localparam logic [4:0] F5_DIV   = 5'h03;
	localparam logic [4:0] F5_SGNJ  = 5'h04;
	localparam logic [4:0] F5_MINMAX = 5'h05;
	localparam logic [4:0] F5_CVT_FF = 5'h08;
	localparam logic [4:0] F5_SQRT  = 5'h0B;
	localparam logic [4:0] F5_CMP   = 5'h14;
	localparam logic [4:0] F5_CVT_FI = 5'h18;
	localparam logic [4:0] F5_CVT_IF = 5'h1A;
	localparam logic [4:0] F5_MV_XF = 5'h1C;
	localparam logic [4:0] F5_MV_FX = 5'h1E;

	// Operation codes
	localparam logic [5:0] OP_FLW      = 6'd0;
	localparam logic [5:0] OP_FSW      = 6'd2;
	localparam logic [5:0] OP_FMADD    = 6'd4;
	localparam logic [5:0] OP_FADD     = 6'd8;
	localparam logic [5:0] OP_FSUB     = 6'd9;
	localparam logic [5:0] OP_FMUL     = 6'd10;
	localparam logic [5:0] OP_FDIV     = 6'd11;
	localparam logic [5:0] OP_FSQRT    = 6'd12;
	localparam logic [5:0] OP_FSGNJ    = 6'd13;
	localparam logic [5:0] OP_FMIN     = 6'd16;
	localparam logic [5:0] OP_FLE      = 6'd18;
	localparam logic [5:0] OP_FCVT_S_D = 6'd21;
	localparam logic [5:0] OP_FCVT_D_S = 6'd22;
	localparam logic [5:0] OP_FCVT_W_F = 6'd23;
	localparam logic [5:0] OP_FCVT_F_W = 6'd27;
	localparam logic [5:0] OP_FMV_X_F  = 6'd31;
	localparam logic [5:0] OP_FCLASS   = 6'd32;
	localparam logic [5:0] OP_FMV_F_X  = 6'd33;

	// Decoded fields that do not come straight from the word
	typedef struct packed {
		logic              is_fp;
		logic              ill;
		logic [5:0]        op;
		logic              dbl;
		logic signed [11:0] off;
		logic              dint;
		logic              sint;
	} dec_t;

endpackage

FILE: rtl/core/fpd_decode.sv
module fpd_decode
	import fpd_pkg::*;
(
	input  logic [31:0] word,
	input  logic        xlen_is_64,
	output dec_t        dec
);

	logic [6:0] opc;
	logic [2:0] rm;
	logic [4:0] rs2;
	logic [6:0] func;
	logic       fdbl;
	logic       int_rs2_ok;
	dec_t       raw;

	assign opc  = word[6:0];
	assign rm   = word[14:12];
	assign rs2  = word[24:20];
	assign func = word[31:25];
	assign fdbl = func[0];
	assign int_rs2_ok = (rs2[4:1] == 4'd0) || ((rs2[4:2] == 3'd0) && xlen_is_64);

	// Decode the major opcode and the OP-FP function group
	always_comb begin
		raw = '0;
		raw.is_fp = 1'b1;
		case (opc)
			OPC_LOAD_FP: begin
				if (rm == WIDTH_W || rm == WIDTH_D) begin
					raw.dbl  = rm[0];
					raw.op   = OP_FLW + {5'd0, rm[0]};
					raw.off  = word[31:20];
					raw.sint = 1'b1;
				end else begin
					raw.ill = 1'b1;
				end
			end
			OPC_STORE_FP: begin
				if (rm == WIDTH_W || rm == WIDTH_D) begin
					raw.dbl  = rm[0];
					raw.op   = OP_FSW + {5'd0, rm[0]};
					raw.off  = {word[31:25], word[11:7]};
					raw.sint = 1'b1;
				end else begin
					raw.ill = 1'b1;
				end
			end
			OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD: begin
				if (!func[1]) begin
					raw.dbl = func[0];
					raw.op  = OP_FMADD + {4'd0, word[3:2]};
				end else begin
					raw.ill = 1'b1;
				end
			end
			OPC_OP_FP: begin
				raw.dbl = fdbl;
				if (func[1]) begin
					raw.ill = 1'b1;
				end else begin
					case (func[6:2])
						F5_ADD:  raw.op = OP_FADD;
						F5_SUB:  raw.op = OP_FSUB;
						F5_MUL:  raw.op = OP_FMUL;
						F5_DIV:  raw.op = OP_FDIV;
						F5_SQRT: raw.op = OP_FSQRT;
						F5_SGNJ: begin
							if (rm <= 3'd2) raw.op = OP_FSGNJ + {3'd0, rm};
							else raw.ill = 1'b1;
						end
						F5_MINMAX: begin
							if (rm <= 3'd1) raw.op = OP_FMIN + {3'd0, rm};
							else raw.ill = 1'b1;
						end
						F5_CMP: begin
							if (rm <= 3'd2) begin
								raw.op   = OP_FLE + {3'd0, rm};
								raw.dint = 1'b1;
							end else begin
								raw.ill = 1'b1;
							end
						end
						F5_CVT_FF: begin
							if (rs2 == {4'd0, ~fdbl}) raw.op = fdbl ? OP_FCVT_D_S : OP_FCVT_S_D;
							else raw.ill = 1'b1;
						end
						F5_CVT_FI: begin
							if (int_rs2_ok) begin
								raw.op   = OP_FCVT_W_F + {4'd0, rs2[1:0]};
								raw.dint = 1'b1;
							end else begin
								raw.ill = 1'b1;
							end
						end
						F5_CVT_IF: begin
							if (int_rs2_ok) begin
								raw.op   = OP_FCVT_F_W + {4'd0, rs2[1:0]};
								raw.sint = 1'b1;
							end else begin
								raw.ill = 1'b1;
							end
						end
						F5_MV_XF: begin
							if (rm == 3'd0 && (!fdbl || xlen_is_64)) begin
								raw.op   = OP_FMV_X_F;
								raw.dint = 1'b1;
							end else if (rm == 3'd1) begin
								raw.op   = OP_FCLASS;
								raw.dint = 1'b1;
							end else begin
								raw.ill = 1'b1;
							end
						end
						F5_MV_FX: begin
							if (rm == 3'd0 && (!fdbl || xlen_is_64)) begin
								raw.op   = OP_FMV_F_X;
								raw.sint = 1'b1;
							end else begin
								raw.ill = 1'b1;
							end
						end
						default: raw.ill = 1'b1;
					endcase
				end
			end
			default: raw.is_fp = 1'b0;
		endcase
	end

	// Drop everything but the flags on an illegal word
	always_comb begin
		dec = raw;
		if (raw.ill) begin
			dec.op   = '0;
			dec.dbl  = 1'b0;
			dec.off  = '0;
			dec.dint = 1'b0;
			dec.sint = 1'b0;
		end
	end

endmodule

FILE: rtl/core/fp_instruction_decoder.sv
// Floating-point instruction decoder for the single- and double-precision subset.
// Input: pulse start with instr_word; a transaction is taken at each edge where
// start is high and busy is low. busy is always low, so one instruction can be
// taken every cycle.
// Output: done marks a result for exactly one cycle, with the decoded operation,
// precision, register fields, rounding mode, offset and int-side flags. There is
// no back-pressure: the receiver must take each result in the cycle it appears.
// Pipeline: an input register ahead of the decoder and a result register behind it
// drive done and the decoded fields.
// Throughput: one instruction per cycle.
// Configuration: cfg_we/cfg_wdata write xlen_is_64 (1 = 64-bit integer side);
// write it only with no transaction in flight.
// Reset: arst_n clears the pipeline valids (no result in flight) and sets
// xlen_is_64 to 1.
module fp_instruction_decoder
	import fpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        instr_word,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	output logic               done,
	output logic               is_fp_opcode,
	output logic               illegal,
	output logic [5:0]         operation,
	output logic               is_double,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src1_reg,
	output logic [4:0]         src2_reg,
	output logic [4:0]         src3_reg,
	output logic [2:0]         round_mode,
	output logic signed [11:0] offset,
	output logic               dest_is_int,
	output logic               src_is_int
);

	logic        xlen_q;
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        valid_s2;
	logic [31:0] word_s2;
	dec_t        dec;
	dec_t        dec_s2;

	assign busy = 1'b0;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) xlen_q <= 1'b1;
		else if (cfg_we) xlen_q <= cfg_wdata;
	end

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) word_s1 <= instr_word;
	end

	fpd_decode u_decode (
		.word       (word_s1),
		.xlen_is_64 (xlen_q),
		.dec        (dec)
	);

	// Advance the decoded result into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			word_s2 <= word_s1;
			dec_s2  <= dec;
		end
	end

	assign done         = valid_s2;
	assign is_fp_opcode = dec_s2.is_fp;
	assign illegal      = dec_s2.ill;
	assign operation    = dec_s2.op;
	assign is_double    = dec_s2.dbl;
	assign offset       = dec_s2.off;
	assign dest_is_int  = dec_s2.dint;
	assign src_is_int   = dec_s2.sint;
	assign dest_reg     = word_s2[11:7];
	assign src1_reg     = word_s2[19:15];
	assign src2_reg     = word_s2[24:20];
	assign src3_reg     = word_s2[31:27];
	assign round_mode   = word_s2[14:12];

endmodule

FILE: tb/sv/fp_instruction_decoder_checker.sv
`timescale 1ns / 1ps

// Watches the instruction and result channels of the decoder, predicts each
// decode and compares the results in order.
module fp_instruction_decoder_checker
	import fpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [31:0]        instr_word,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               done,
	input  logic               is_fp_opcode,
	input  logic               illegal,
	input  logic [5:0]         operation,
	input  logic               is_double,
	input  logic [4:0]         dest_reg,
	input  logic [4:0]         src1_reg,
	input  logic [4:0]         src2_reg,
	input  logic [4:0]         src3_reg,
	input  logic [2:0]         round_mode,
	input  logic signed [11:0] offset,
	input  logic               dest_is_int,
	input  logic               src_is_int,
	output int                 mismatches,
	output int                 outstanding,
	output int                 decoded,
	output int                 fp_seen,
	output int                 illegal_seen
);

	typedef struct packed {
		logic [31:0] word;
		dec_t        dec;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [4:0]  rs3;
		logic [2:0]  rm;
	} decoded_instr_t;

	decoded_instr_t pending_decodes[$];
	decoded_instr_t head;
	decoded_instr_t fresh;
	logic           xlen64;

	// Decode one word the way the F/D encoding defines it
	function automatic dec_t decode_fp(input logic [31:0] w, input logic x64);
		dec_t       d;
		logic [4:0] grp;
		logic [2:0] rm;
		logic [4:0] rs2;
		logic       dbl;
		d = '0;
		grp = w[31:27];
		rm = w[14:12];
		rs2 = w[24:20];
		dbl = w[25];
		d.is_fp = 1'b1;
		case (w[6:0])
			OPC_LOAD_FP, OPC_STORE_FP: begin
				if (rm == WIDTH_W || rm == WIDTH_D) begin
					d.dbl = rm[0];
					d.sint = 1'b1;
					if (w[6:0] == OPC_LOAD_FP) begin
						d.op = OP_FLW + {5'd0, rm[0]};
						d.off = w[31:20];
					end else begin
						d.op = OP_FSW + {5'd0, rm[0]};
						d.off = {w[31:25], w[11:7]};
					end
				end else begin
					d.ill = 1'b1;
				end
			end
			OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD: begin
				if (!w[26]) begin
					d.dbl = dbl;
					d.op = OP_FMADD + {4'd0, w[3:2]};
				end else begin
					d.ill = 1'b1;
				end
			end
			OPC_OP_FP: begin
				d.dbl = dbl;
				if (w[26]) begin
					d.ill = 1'b1;
				end else begin
					case (grp)
						F5_ADD:  d.op = OP_FADD;
						F5_SUB:  d.op = OP_FSUB;
						F5_MUL:  d.op = OP_FMUL;
						F5_DIV:  d.op = OP_FDIV;
						F5_SQRT: d.op = OP_FSQRT;
						F5_SGNJ: begin
							if (rm <= 3'd2) d.op = OP_FSGNJ + {3'd0, rm};
							else d.ill = 1'b1;
						end
						F5_MINMAX: begin
							if (rm <= 3'd1) d.op = OP_FMIN + {3'd0, rm};
							else d.ill = 1'b1;
						end
						F5_CMP: begin
							if (rm <= 3'd2) begin
								d.op = OP_FLE + {3'd0, rm};
								d.dint = 1'b1;
							end else begin
								d.ill = 1'b1;
							end
						end
						F5_CVT_FF: begin
							// rs2 names the source format, the opposite of fmt
							if (rs2 == {4'd0, !dbl}) d.op = dbl ? OP_FCVT_D_S : OP_FCVT_S_D;
							else d.ill = 1'b1;
						end
						F5_CVT_FI: begin
							if (rs2 <= 5'd1 || (rs2 <= 5'd3 && x64)) begin
								d.op = OP_FCVT_W_F + {1'b0, rs2};
								d.dint = 1'b1;
							end else begin
								d.ill = 1'b1;
							end
						end
						F5_CVT_IF: begin
							if (rs2 <= 5'd1 || (rs2 <= 5'd3 && x64)) begin
								d.op = OP_FCVT_F_W + {1'b0, rs2};
								d.sint = 1'b1;
							end else begin
								d.ill = 1'b1;
							end
						end
						F5_MV_XF: begin
							if (rm == 3'd0 && (!dbl || x64)) begin
								d.op = OP_FMV_X_F;
								d.dint = 1'b1;
							end else if (rm == 3'd1) begin
								d.op = OP_FCLASS;
								d.dint = 1'b1;
							end else begin
								d.ill = 1'b1;
							end
						end
						F5_MV_FX: begin
							if (rm == 3'd0 && (!dbl || x64)) begin
								d.op = OP_FMV_F_X;
								d.sint = 1'b1;
							end else begin
								d.ill = 1'b1;
							end
						end
						default: d.ill = 1'b1;
					endcase
				end
			end
			default: d.is_fp = 1'b0;
		endcase
		// An illegal word carries nothing but its flags
		if (d.ill) begin
			d.op = '0;
			d.dbl = 1'b0;
			d.off = '0;
			d.dint = 1'b0;
			d.sint = 1'b0;
		end
		return d;
	endfunction

	task automatic report(input string msg);
		$display("%0t ns: ERROR %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s of instruction %08h: got %0h, expected %0h",
				name, head.word, got, want));
	endtask

	// Retire results, queue new predictions and track the xlen register
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_decodes.delete();
			xlen64 <= 1'b1;
			mismatches = 0;
			outstanding = 0;
			decoded = 0;
			fp_seen = 0;
			illegal_seen = 0;
		end else begin
			if (done) begin
				if (pending_decodes.size() == 0) begin
					report("result transaction with no instruction waiting");
				end else begin
					head = pending_decodes.pop_front();
					check_field("is_fp_opcode", 32'(is_fp_opcode), 32'(head.dec.is_fp));
					check_field("illegal", 32'(illegal), 32'(head.dec.ill));
					check_field("operation", 32'(operation), 32'(head.dec.op));
					check_field("is_double", 32'(is_double), 32'(head.dec.dbl));
					check_field("dest_reg", 32'(dest_reg), 32'(head.rd));
					check_field("src1_reg", 32'(src1_reg), 32'(head.rs1));
					check_field("src2_reg", 32'(src2_reg), 32'(head.rs2));
					check_field("src3_reg", 32'(src3_reg), 32'(head.rs3));
					check_field("round_mode", 32'(round_mode), 32'(head.rm));
					check_field("offset", 32'(offset), 32'(head.dec.off));
					check_field("dest_is_int", 32'(dest_is_int), 32'(head.dec.dint));
					check_field("src_is_int", 32'(src_is_int), 32'(head.dec.sint));
					decoded++;
					if (head.dec.is_fp) fp_seen++;
					if (head.dec.ill) illegal_seen++;
				end
			end
			if (start && !busy) begin
				fresh.word = instr_word;
				fresh.dec = decode_fp(instr_word, xlen64);
				fresh.rd = instr_word[11:7];
				fresh.rs1 = instr_word[19:15];
				fresh.rs2 = instr_word[24:20];
				fresh.rs3 = instr_word[31:27];
				fresh.rm = instr_word[14:12];
				pending_decodes.push_back(fresh);
			end
			if (cfg_we) xlen64 <= cfg_wdata;
			outstanding = pending_decodes.size();
		end
	end

endmodule

FILE: tb/sv/fp_instruction_decoder_tb.sv
`timescale 1ns / 1ps

module fp_instruction_decoder_tb
	import fpd_pkg::*;
();

	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 115;
	localparam int IDLE_RATE [PHASES] = '{37, 37, 88, 88, 0, 0};
	localparam logic PHASE_XLEN64 [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
	localparam logic [4:0] FP_GROUPS [13] = '{F5_ADD, F5_SUB, F5_MUL, F5_DIV, F5_SGNJ,
		F5_MINMAX, F5_CVT_FF, F5_SQRT, F5_CMP, F5_CVT_FI, F5_CVT_IF, F5_MV_XF, F5_MV_FX};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [31:0]        instr_word = '0;
	logic               cfg_we = 1'b0;
	logic               cfg_wdata = 1'b0;
	logic               busy;
	logic               done;
	logic               is_fp_opcode;
	logic               illegal;
	logic [5:0]         operation;
	logic               is_double;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic [4:0]         src3_reg;
	logic [2:0]         round_mode;
	logic signed [11:0] offset;
	logic               dest_is_int;
	logic               src_is_int;
	int                 mismatches;
	int                 outstanding;
	int                 decoded;
	int                 fp_seen;
	int                 illegal_seen;

	fp_instruction_decoder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.instr_word(instr_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .is_fp_opcode(is_fp_opcode), .illegal(illegal),
		.operation(operation), .is_double(is_double), .dest_reg(dest_reg),
		.src1_reg(src1_reg), .src2_reg(src2_reg), .src3_reg(src3_reg),
		.round_mode(round_mode), .offset(offset), .dest_is_int(dest_is_int),
		.src_is_int(src_is_int)
	);

	fp_instruction_decoder_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.instr_word(instr_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .is_fp_opcode(is_fp_opcode), .illegal(illegal),
		.operation(operation), .is_double(is_double), .dest_reg(dest_reg),
		.src1_reg(src1_reg), .src2_reg(src2_reg), .src3_reg(src3_reg),
		.round_mode(round_mode), .offset(offset), .dest_is_int(dest_is_int),
		.src_is_int(src_is_int), .mismatches(mismatches), .outstanding(outstanding),
		.decoded(decoded), .fp_seen(fp_seen), .illegal_seen(illegal_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bound the run in case a result never shows up
	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [31:0] opfp_word(input logic [4:0] grp, input logic [1:0] fmt,
			input logic [4:0] rs2, input logic [2:0] rm);
		return {grp, fmt, rs2, 5'd17, rm, 5'd10, OPC_OP_FP};
	endfunction

	// Mostly well-formed FP words with random content, some arbitrary words
	function automatic logic [31:0] random_instr();
		logic [31:0] w;
		logic [4:0]  grp;
		int          pick;
		w = $urandom();
		pick = $urandom_range(99);
		if (pick < 10) return w;
		if (pick < 25) begin
			w[6:0] = $urandom_range(1) ? OPC_LOAD_FP : OPC_STORE_FP;
			if ($urandom_range(9) != 0) w[14:12] = $urandom_range(1) ? WIDTH_D : WIDTH_W;
		end else if (pick < 40) begin
			w[6:0] = OPC_FMADD;
			w[3:2] = 2'($urandom_range(3));
			if ($urandom_range(9) != 0) w[26] = 1'b0;
		end else begin
			w[6:0] = OPC_OP_FP;
			grp = ($urandom_range(9) != 0) ? FP_GROUPS[$urandom_range(12)] : w[31:27];
			w[31:27] = grp;
			if ($urandom_range(9) != 0) w[26] = 1'b0;
			// steer rm and rs2 into the legal ranges most of the time
			if ($urandom_range(4) != 0) begin
				w[24:20] = 5'($urandom_range(3));
				case (grp)
					F5_SGNJ, F5_CMP:   w[14:12] = 3'($urandom_range(2));
					F5_MINMAX, F5_MV_XF: w[14:12] = 3'($urandom_range(1));
					F5_MV_FX:          w[14:12] = 3'd0;
					default: ;
				endcase
			end
		end
		return w;
	endfunction

	// Offer one instruction, idling first at the given rate; hold it until taken
	task automatic send_instr(input logic [31:0] word, input int idle_pct);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			instr_word <= $urandom();
			@(posedge clk);
		end
		start <= 1'b1;
		instr_word <= word;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
	endtask

	// Stop offering and wait until every decode has come back
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_xlen(input logic value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [31:0] directed[$];
		logic [31:0] rv32_words[$];
		directed = '{
			32'h0000_0000, 32'hFFFF_FFFF,
			{12'h7FF, 5'd31, WIDTH_W, 5'd31, OPC_LOAD_FP},
			{12'h800, 5'd0, WIDTH_D, 5'd0, OPC_LOAD_FP},
			{12'hABC, 5'd5, 3'b100, 5'd6, OPC_LOAD_FP},
			{7'h3F, 5'd1, 5'd2, WIDTH_W, 5'h1F, OPC_STORE_FP},
			{7'h40, 5'd30, 5'd29, WIDTH_D, 5'h00, OPC_STORE_FP},
			{5'd31, 2'b00, 5'd1, 5'd2, 3'b111, 5'd3, OPC_FMADD},
			{5'd0, 2'b01, 5'd31, 5'd30, 3'b000, 5'd29, OPC_FMSUB},
			{5'd16, 2'b00, 5'd15, 5'd14, 3'b001, 5'd13, OPC_FNMSUB},
			{5'd8, 2'b01, 5'd7, 5'd6, 3'b100, 5'd5, OPC_FNMADD},
			{5'd8, 2'b11, 5'd7, 5'd6, 3'b100, 5'd5, OPC_FNMADD},
			opfp_word(F5_ADD, 2'b00, 5'd5, 3'b111),
			opfp_word(F5_SQRT, 2'b01, 5'd31, 3'b000),
			opfp_word(F5_SGNJ, 2'b00, 5'd4, 3'b010),
			opfp_word(F5_SGNJ, 2'b01, 5'd4, 3'b011),
			opfp_word(F5_MINMAX, 2'b01, 5'd8, 3'b001),
			opfp_word(F5_CMP, 2'b00, 5'd9, 3'b010),
			opfp_word(F5_CVT_FF, 2'b00, 5'd1, 3'b111),
			opfp_word(F5_CVT_FF, 2'b01, 5'd1, 3'b000),
			opfp_word(F5_CVT_FI, 2'b01, 5'd3, 3'b001),
			opfp_word(F5_CVT_FI, 2'b00, 5'd4, 3'b001),
			opfp_word(F5_CVT_IF, 2'b01, 5'd2, 3'b100),
			opfp_word(F5_MV_XF, 2'b01, 5'd0, 3'b000),
			opfp_word(F5_MV_XF, 2'b00, 5'd0, 3'b001),
			opfp_word(F5_MV_FX, 2'b00, 5'd0, 3'b000),
			opfp_word(F5_ADD, 2'b10, 5'd0, 3'b000)
		};
		// A 64-bit conversion and a double move fall away on a 32-bit target; a single move stays
		rv32_words = '{
			opfp_word(F5_CVT_FI, 2'b00, 5'd2, 3'b001),
			opfp_word(F5_MV_FX, 2'b01, 5'd0, 3'b000),
			opfp_word(F5_MV_XF, 2'b00, 5'd0, 3'b000)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners at the reset xlen, then the 32-bit ones
		foreach (directed[i]) send_instr(directed[i], 37);
		write_xlen(1'b0);
		foreach (rv32_words[i]) send_instr(rv32_words[i], 0);

		// Random phases over idle rates and both xlen settings
		for (int p = 0; p < PHASES; p++) begin
			write_xlen(PHASE_XLEN64[p]);
			repeat (PHASE_ITEMS) send_instr(random_instr(), IDLE_RATE[p]);
		end

		drain();
		repeat (5) @(posedge clk);
		$display("Decoded %0d instructions (%0d with an FP opcode, %0d illegal)", decoded,
			fp_seen, illegal_seen);
		$display("across RV64 and RV32 settings and sender idle rates of 37, 88 and 0 percent");
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
